@@ sv/htwd_pkg.sv @@
// shared types and constants for the tree-walk symbol decoder
// depends on nothing; imported by the top level
package htwd_pkg;

    localparam int NODE_CAPACITY    = 512;
    localparam int OPEN_STACK_DEPTH = 256;
    localparam int BITS_PER_BYTE    = 8;

    localparam int NIDX_W  = $clog2(NODE_CAPACITY);
    localparam int NCNT_W  = $clog2(NODE_CAPACITY + 1);
    localparam int SADDR_W = $clog2(OPEN_STACK_DEPTH);
    localparam int SLVL_W  = $clog2(OPEN_STACK_DEPTH + 1);
    localparam int BCNT_W  = $clog2(BITS_PER_BYTE);

    // marker byte that announces a leaf symbol
    localparam logic [7:0] LEAF_MARK = 8'h31;

    typedef enum logic {
        OP_TREE = 1'b0,
        OP_DATA = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_WALK,
        ST_FLUSH
    } seq_state_t;

    typedef struct packed {
        logic       leaf;
        logic [7:0] symbol;
    } node_info_t;

    typedef struct packed {
        logic              left_set;
        logic [NIDX_W-1:0] idx;
    } stack_entry_t;

endpackage

@@ sv/huffman_tree_walk_decoder.sv @@
// top level of the tree-walk symbol decoder: tree builder, walk sequencer, output stage
// depends on htwd_pkg and htwd_ram
//
// usage
//   cfg channel: one write sets total_symbols; write only while the block is idle.
//     the count is latched into the symbol counter when a tree with internal nodes completes.
//   s channel: s_operation selects a tree byte (preorder, '1' marks a leaf and its
//     symbol byte follows) or a compressed data byte (walked msb first).
//   m channel: one transfer per decoded symbol, up to eight per data byte;
//     m_last_of_run marks the last symbol of a data byte, m_message_done the
//     symbol that brings the remaining count to zero.
// sequence
//   tree byte: taken in idle; when a right child closes a node and the next open
//     node comes back from the stack memory, the pop state follows before the next byte.
//   data byte: the transfer issues the first node read, the walk state then
//     takes one walked bit at a time (8 at most) and a flush state sends the
//     last symbol of the byte to the output register. one dependent node read per bit.
//   ignored bytes are taken in idle without leaving it.
// reset
//   synchronous, active low; counters and flags clear, memories are not
//   cleared since only written entries are ever read. no clearing pass.
// stall
//   a stalled receiver holds the output register; the walk then waits on the
//   next found symbol and s_ready stays low until the byte is finished.
module huffman_tree_walk_decoder
    import htwd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_total_symbols,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_in_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_decoded_symbol,
    output logic        m_last_of_run,
    output logic        m_message_done
);

    // sequencer
    seq_state_t state_reg, state_next;

    // tree build state
    logic [SLVL_W-1:0] level_reg,      level_next;
    logic [NCNT_W-1:0] nodes_reg,      nodes_next;
    logic              await_reg,      await_next;
    logic              tree_ready_reg, tree_ready_next;
    stack_entry_t      top_reg,        top_next;
    logic [NIDX_W-1:0] root_left_reg,  root_left_next;
    logic [NIDX_W-1:0] root_right_reg, root_right_next;

    // walk state
    logic [31:0]       total_reg,      total_next;
    logic [31:0]       sl_reg,         sl_next;
    logic              pos_root_reg,   pos_root_next;
    logic              pend_reg,       pend_next;
    logic [BCNT_W-1:0] bits_reg,       bits_next;
    logic [7:0]        byte_reg,       byte_next;

    // one-symbol hold stage, so the last symbol of a byte can be flagged
    logic              hold_valid_reg, hold_valid_next;
    logic [7:0]        hold_sym_reg,   hold_sym_next;
    logic              hold_done_reg,  hold_done_next;

    // output register
    logic              out_valid_reg,  out_valid_next;
    logic [7:0]        out_sym_reg,    out_sym_next;
    logic              out_last_reg,   out_last_next;
    logic              out_done_reg,   out_done_next;

    // memory ports
    logic              info_we;
    logic [NIDX_W-1:0] info_waddr;
    node_info_t        info_wdata;
    logic              left_we, right_we;
    logic [NIDX_W-1:0] child_waddr;
    logic [NIDX_W-1:0] child_wdata;
    logic              node_re;
    logic [NIDX_W-1:0] node_raddr;
    node_info_t        info_rdata;
    logic [NIDX_W-1:0] left_rdata, right_rdata;
    logic              stk_we, stk_re;
    logic [SADDR_W-1:0] stk_waddr, stk_raddr;
    stack_entry_t      stk_wdata, stk_rdata;

    // scratch
    logic              out_free;
    logic              stall;
    logic              is_int;
    logic              new_leaf;
    logic [NIDX_W-1:0] new_idx;
    logic [SLVL_W-1:0] lvl_m1, lvl_m2;
    logic              pos_root_v;
    logic [31:0]       sl_v;
    logic [NIDX_W-1:0] src_left, src_right;

    // node table, split by field: leaf flag and symbol, left child, right child
    htwd_ram #(.WIDTH($bits(node_info_t)), .DEPTH(NODE_CAPACITY)) u_info_ram (
        .aclk  (aclk),
        .we    (info_we),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (info_rdata)
    );

    htwd_ram #(.WIDTH(NIDX_W), .DEPTH(NODE_CAPACITY)) u_left_ram (
        .aclk  (aclk),
        .we    (left_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (left_rdata)
    );

    htwd_ram #(.WIDTH(NIDX_W), .DEPTH(NODE_CAPACITY)) u_right_ram (
        .aclk  (aclk),
        .we    (right_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (right_rdata)
    );

    // open node stack; the top entry lives in top_reg, the rest in memory
    htwd_ram #(.WIDTH($bits(stack_entry_t)), .DEPTH(OPEN_STACK_DEPTH)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign cfg_ready        = 1'b1;
    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = out_valid_reg;
    assign m_decoded_symbol = out_sym_reg;
    assign m_last_of_run    = out_last_reg;
    assign m_message_done   = out_done_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign lvl_m1   = level_reg - SLVL_W'(1);
    assign lvl_m2   = level_reg - SLVL_W'(2);
    assign new_idx  = nodes_reg[NIDX_W-1:0];

    // children of the current walk position: root kept in flops, others from the read
    assign src_left  = pos_root_v ? root_left_reg  : left_rdata;
    assign src_right = pos_root_v ? root_right_reg : right_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        level_next      = level_reg;
        nodes_next      = nodes_reg;
        await_next      = await_reg;
        tree_ready_next = tree_ready_reg;
        top_next        = top_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        total_next      = total_reg;
        sl_next         = sl_reg;
        pos_root_next   = pos_root_reg;
        pend_next       = pend_reg;
        bits_next       = bits_reg;
        byte_next       = byte_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_done_next  = hold_done_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;

        info_we     = 1'b0;
        info_waddr  = new_idx;
        info_wdata  = '0;
        left_we     = 1'b0;
        right_we    = 1'b0;
        child_waddr = top_reg.idx;
        child_wdata = new_idx;
        node_re     = 1'b0;
        node_raddr  = '0;
        stk_we      = 1'b0;
        stk_waddr   = lvl_m1[SADDR_W-1:0];
        stk_wdata   = '{left_set: 1'b1, idx: top_reg.idx};
        stk_re      = 1'b0;
        stk_raddr   = lvl_m2[SADDR_W-1:0];

        is_int     = 1'b0;
        new_leaf   = 1'b0;
        stall      = 1'b0;
        pos_root_v = pos_root_reg;
        sl_v       = sl_reg;

        if (cfg_valid) begin
            total_next = cfg_total_symbols;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_operation == OP_TREE && !tree_ready_reg) begin
                    // decide whether this byte allocates a node
                    if (await_reg) begin
                        await_next = 1'b0;
                        new_leaf   = (nodes_reg != NCNT_W'(NODE_CAPACITY));
                    end else if (nodes_reg != NCNT_W'(NODE_CAPACITY)) begin
                        if (s_in_byte == LEAF_MARK) begin
                            await_next = 1'b1;
                        end else if (level_reg != SLVL_W'(OPEN_STACK_DEPTH)) begin
                            is_int = 1'b1;
                        end
                    end

                    if (new_leaf || is_int) begin
                        info_we    = 1'b1;
                        info_wdata = is_int ? node_info_t'{leaf: 1'b0, symbol: 8'h00}
                                            : node_info_t'{leaf: 1'b1, symbol: s_in_byte};
                        nodes_next = nodes_reg + NCNT_W'(1);

                        if (level_reg == '0) begin
                            if (is_int) begin
                                top_next   = '{left_set: 1'b0, idx: new_idx};
                                level_next = SLVL_W'(1);
                            end else begin
                                // root is a leaf: complete, nothing to decode
                                tree_ready_next = 1'b1;
                                pos_root_next   = 1'b1;
                                sl_next         = '0;
                            end
                        end else if (!top_reg.left_set) begin
                            left_we = 1'b1;
                            if (top_reg.idx == '0) begin
                                root_left_next = new_idx;
                            end
                            if (is_int) begin
                                // park the parent in memory, new node becomes top
                                stk_we     = 1'b1;
                                top_next   = '{left_set: 1'b0, idx: new_idx};
                                level_next = level_reg + SLVL_W'(1);
                            end else begin
                                top_next.left_set = 1'b1;
                            end
                        end else begin
                            right_we = 1'b1;
                            if (top_reg.idx == '0) begin
                                root_right_next = new_idx;
                            end
                            if (is_int) begin
                                // pop and push in one go
                                top_next = '{left_set: 1'b0, idx: new_idx};
                            end else begin
                                level_next = lvl_m1;
                                if (level_reg == SLVL_W'(1)) begin
                                    tree_ready_next = 1'b1;
                                    pos_root_next   = 1'b1;
                                    sl_next         = total_reg;
                                end else begin
                                    stk_re     = 1'b1;
                                    state_next = ST_POP;
                                end
                            end
                        end
                    end
                end else if (s_valid && s_operation == OP_DATA && tree_ready_reg
                             && sl_reg != '0) begin
                    // first bit lookup goes out with the transfer
                    node_re    = 1'b1;
                    node_raddr = s_in_byte[BITS_PER_BYTE-1] ? src_right : src_left;
                    byte_next  = s_in_byte << 1;
                    bits_next  = BCNT_W'(BITS_PER_BYTE - 1);
                    pend_next  = 1'b1;
                    state_next = ST_WALK;
                end
            end

            ST_POP: begin
                top_next   = stk_rdata;
                state_next = ST_IDLE;
            end

            ST_WALK: begin
                stall = pend_reg && info_rdata.leaf && hold_valid_reg && !out_free;
                if (!stall) begin
                    if (pend_reg) begin
                        if (info_rdata.leaf) begin
                            if (hold_valid_reg) begin
                                out_valid_next = 1'b1;
                                out_sym_next   = hold_sym_reg;
                                out_last_next  = 1'b0;
                                out_done_next  = hold_done_reg;
                            end
                            hold_valid_next = 1'b1;
                            hold_sym_next   = info_rdata.symbol;
                            hold_done_next  = (sl_reg == 32'd1);
                            sl_v            = sl_reg - 32'd1;
                            pos_root_v      = 1'b1;
                        end else begin
                            pos_root_v = 1'b0;
                        end
                    end
                    pos_root_next = pos_root_v;
                    sl_next       = sl_v;

                    if (bits_reg != '0 && sl_v != '0) begin
                        node_re    = 1'b1;
                        node_raddr = byte_reg[BITS_PER_BYTE-1] ? src_right : src_left;
                        byte_next  = byte_reg << 1;
                        bits_next  = bits_reg - BCNT_W'(1);
                        pend_next  = 1'b1;
                    end else begin
                        pend_next  = 1'b0;
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH: begin
                // last held symbol of the byte leaves flagged as last
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = hold_sym_reg;
                    out_last_next   = 1'b1;
                    out_done_next   = hold_done_reg;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg      <= '0;
            nodes_reg      <= '0;
            await_reg      <= 1'b0;
            tree_ready_reg <= 1'b0;
            total_reg      <= '0;
            sl_reg         <= '0;
            pos_root_reg   <= 1'b1;
            pend_reg       <= 1'b0;
            bits_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            level_reg      <= level_next;
            nodes_reg      <= nodes_next;
            await_reg      <= await_next;
            tree_ready_reg <= tree_ready_next;
            total_reg      <= total_next;
            sl_reg         <= sl_next;
            pos_root_reg   <= pos_root_next;
            pend_reg       <= pend_next;
            bits_reg       <= bits_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        top_reg        <= top_next;
        root_left_reg  <= root_left_next;
        root_right_reg <= root_right_next;
        byte_reg       <= byte_next;
        hold_sym_reg   <= hold_sym_next;
        hold_done_reg  <= hold_done_next;
        out_sym_reg    <= out_sym_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

    // the walk only runs on a finished tree
    a_walk_needs_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> tree_ready_reg)
        else $error("walk started before tree completed");

    // the symbol that ends the message is always the last one of its byte
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_done_reg) |-> out_last_reg)
        else $error("message_done without last_of_run");

    // no held symbol may be left behind when a new byte can be taken
    a_hold_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held symbol lost at end of byte");

    // open stack never grows beyond its depth
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= SLVL_W'(OPEN_STACK_DEPTH))
        else $error("open stack overflow");

endmodule

@@ sv/htwd_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
module htwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
